// File: design/fqd_pkg.sv
// Package for the handle queue with delete: operation codes, controller states
// and the control word handed to each storage cell. No dependencies.
`default_nettype none
package fqd_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int FUNC_BITS       = 2;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ENQUEUE = 2'd0,
        FN_DEQUEUE = 2'd1,
        FN_DELETE  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_HOLD = 2'd2
    } t_state;

    // shift: take the neighbour's word; load: take the broadcast word (wins)
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: design/fqd_if.sv
// Valid/ready channel interfaces for the handle queue: operation words in,
// result words out. Depends on fqd_pkg.
`default_nettype none
interface fqd_in_if #(
    parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [fqd_pkg::FUNC_BITS-1:0]  func;
    logic [HANDLE_BITS-1:0]         handle_in;

    modport source (output valid, output func, output handle_in, input ready);
    modport sink   (input valid, input func, input handle_in, output ready);
endinterface

interface fqd_out_if #(
    parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF,
    parameter int LEN_BITS    = $clog2(fqd_pkg::DEPTH_DEF + 1)
);
    logic                   valid;
    logic                   ready;
    logic                   status;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [LEN_BITS-1:0]    length;

    modport source (output valid, output status, output handle_out, output length,
                    input ready);
    modport sink   (input valid, input status, input handle_out, input length,
                    output ready);
endinterface
`default_nettype wire

// File: design/fifo_queue_with_delete.sv
// Bounded FIFO of nonzero handles with delete of the oldest matching handle.
// Channel i_in carries operation words (func, handle_in); o_out carries
// result words (status, handle_out, length). Both are valid/ready; a word
// moves at a clock edge with valid and ready high.
// Storage is a chain of DEPTH cells with the oldest handle in cell 0.
// Enqueue writes the cell at the current length, dequeue shifts the chain.
// Enqueue, dequeue, rejected and unused operations put their result in the
// output register at the accepting edge. Delete rotates the occupied cells
// once through the head comparator, dropping the first match; its result is
// registered at the end of the rotation, which holds the input closed.
// Throughput: one enqueue or dequeue per cycle while results are taken.
// When the receiver stalls, one finished result waits in a hold register
// while the output register is full; the input closes then.
// Reset (i_rst_n low, synchronous) empties the queue and drops any result;
// cell contents are not cleared and are never read before being written.
// Depends on fqd_pkg, fqd_if and fqd_cell.
`default_nettype none
module fifo_queue_with_delete #(
    parameter int DEPTH       = fqd_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fqd_in_if.sink    i_in,
    fqd_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    fqd_pkg::t_state r_state, n_state;

    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_found, n_found;
    logic [HANDLE_BITS-1:0] r_key;

    logic                   r_ov, n_ov;
    logic                   r_o_status;
    logic [HANDLE_BITS-1:0] r_o_handle;
    logic [CW-1:0]          r_o_len;
    logic                   r_h_status;
    logic [HANDLE_BITS-1:0] r_h_handle;
    logic [CW-1:0]          r_h_len;

    logic [HANDLE_BITS-1:0] w_data [DEPTH];
    fqd_pkg::t_cell_ctl     w_ctl  [DEPTH];

    logic                   w_acc;
    logic                   w_out_free;
    logic                   w_in_ready;
    logic                   w_key_nz;
    logic                   w_start_scan;
    logic                   w_last;
    logic                   w_match;
    logic                   w_shift;
    logic                   w_load;
    logic [IW-1:0]          w_load_idx;
    logic [HANDLE_BITS-1:0] w_load_data;
    logic [CW-1:0]          w_cm1;
    logic                   w_res_valid;
    logic                   w_res_status;
    logic [HANDLE_BITS-1:0] w_res_handle;

    assign w_in_ready = (r_state == fqd_pkg::ST_IDLE);
    assign w_acc      = i_in.valid && w_in_ready;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_key_nz   = (i_in.handle_in != '0);
    assign w_cm1      = r_count - CW'(1);
    assign w_match    = !r_found && (w_data[0] == r_key);
    assign w_last     = (r_left == CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fqd_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (w_start_scan) begin
                        n_state = fqd_pkg::ST_SCAN;
                    end else if (!w_out_free) begin
                        n_state = fqd_pkg::ST_HOLD;
                    end
                end
            end
            fqd_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = w_out_free ? fqd_pkg::ST_IDLE : fqd_pkg::ST_HOLD;
                end
            end
            fqd_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_state = fqd_pkg::ST_IDLE;
                end
            end
            default: n_state = fqd_pkg::ST_IDLE;
        endcase
    end

    // datapath control and results
    always_comb begin
        w_start_scan = 1'b0;
        w_shift      = 1'b0;
        w_load       = 1'b0;
        w_load_idx   = r_count[IW-1:0];
        w_load_data  = i_in.handle_in;
        w_res_valid  = 1'b0;
        w_res_status = 1'b1;
        w_res_handle = '0;
        n_count      = r_count;
        n_left       = r_left;
        n_found      = r_found;
        unique case (r_state)
            fqd_pkg::ST_IDLE: begin
                if (w_acc) begin
                    w_res_valid = 1'b1;
                    unique case (i_in.func)
                        fqd_pkg::FN_ENQUEUE: begin
                            if (w_key_nz && (r_count < CW'(DEPTH))) begin
                                w_load       = 1'b1;
                                n_count      = r_count + CW'(1);
                                w_res_status = 1'b0;
                            end
                        end
                        fqd_pkg::FN_DEQUEUE: begin
                            if (r_count != '0) begin
                                w_shift      = 1'b1;
                                n_count      = w_cm1;
                                w_res_status = 1'b0;
                                w_res_handle = w_data[0];
                            end
                        end
                        fqd_pkg::FN_DELETE: begin
                            if (w_key_nz && (r_count != '0)) begin
                                w_start_scan = 1'b1;
                                w_res_valid  = 1'b0;
                                n_left       = r_count;
                                n_found      = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fqd_pkg::ST_SCAN: begin
                // pop the head; drop it on first match, else append at the tail
                w_shift     = 1'b1;
                w_load_idx  = w_cm1[IW-1:0];
                w_load_data = w_data[0];
                n_left      = r_left - CW'(1);
                if (w_match) begin
                    n_found = 1'b1;
                    n_count = w_cm1;
                end else begin
                    w_load = 1'b1;
                end
                if (w_last) begin
                    w_res_valid  = 1'b1;
                    w_res_status = !(r_found || w_match);
                end
            end
            fqd_pkg::ST_HOLD: ;
            default: ;
        endcase
        n_ov = r_ov && !o_out.ready;
        if ((w_res_valid || (r_state == fqd_pkg::ST_HOLD)) && w_out_free) begin
            n_ov = 1'b1;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            assign w_ctl[k].shift = w_shift;
            assign w_ctl[k].load  = w_load && (w_load_idx == IW'(k));
            fqd_cell #(
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[k]),
                .i_load_data (w_load_data),
                .i_next_data ((k < DEPTH - 1) ? w_data[(k < DEPTH - 1) ? k + 1 : k]
                                              : w_data[k]),
                .o_data      (w_data[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqd_pkg::ST_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_found <= n_found;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_key <= i_in.handle_in;
        end
        if (w_res_valid && w_out_free) begin
            r_o_status <= w_res_status;
            r_o_handle <= w_res_handle;
            r_o_len    <= n_count;
        end else if ((r_state == fqd_pkg::ST_HOLD) && w_out_free) begin
            r_o_status <= r_h_status;
            r_o_handle <= r_h_handle;
            r_o_len    <= r_h_len;
        end
        if (w_res_valid && !w_out_free) begin
            r_h_status <= w_res_status;
            r_h_handle <= w_res_handle;
            r_h_len    <= n_count;
        end
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_status;
    assign o_out.handle_out = r_o_handle;
    assign o_out.length     = r_o_len;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue length beyond depth");

    a_hold_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqd_pkg::ST_HOLD) |-> r_ov)
        else $error("result held while output register empty");

    a_scan_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqd_pkg::ST_SCAN) |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("delete rotation count out of step with length");

    a_scan_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fqd_pkg::ST_SCAN) && w_last) |=> (r_state != fqd_pkg::ST_SCAN))
        else $error("delete rotation overran");
`endif

endmodule
`default_nettype wire

// File: design/fqd_cell.sv
// One storage cell of the handle chain: holds one handle, takes the broadcast
// word on load or its upper neighbour's word on shift. Depends on fqd_pkg.
`default_nettype none
module fqd_cell #(
    parameter int HANDLE_BITS = fqd_pkg::HANDLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire fqd_pkg::t_cell_ctl i_ctl,
    input  wire logic [HANDLE_BITS-1:0] i_load_data,
    input  wire logic [HANDLE_BITS-1:0] i_next_data,
    output logic [HANDLE_BITS-1:0]  o_data
);

    logic [HANDLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire
